@@ src/kvt_pkg.sv @@
`timescale 1ns / 1ps

package kvt_pkg;

    // Number of cells in the table.
    localparam int ENTRIES = 16;
    localparam int KEY_W   = 32;
    localparam int VAL_W   = 32;

    // Request codes.
    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_ERASE  = 2'd1,
        OP_READ   = 2'd2,
        OP_CLEAR  = 2'd3
    } t_opcode;

    // Answer codes.
    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_EXISTS = 2'd1,
        ST_ABSENT = 2'd2,
        ST_FULL   = 2'd3
    } t_status;

    // Request beat.
    typedef struct packed {
        t_opcode                   opcode;
        logic signed [KEY_W-1:0]   key;
        logic signed [VAL_W-1:0]   value;
    } t_in_beat;

    // Answer beat.
    typedef struct packed {
        t_status                   status;
        logic signed [VAL_W-1:0]   read_value;
    } t_out_beat;

    // Command broadcast to every cell.
    typedef struct packed {
        logic             exec;
        t_opcode          opcode;
        logic             any_hit;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } t_cell_cmd;

    // What each cell reports back.
    typedef struct packed {
        logic             match;
        logic             valid;
        logic             claim_out;
        logic [VAL_W-1:0] rd_value;
    } t_cell_stat;

endpackage

@@ src/key_value_table_top.sv @@
`timescale 1ns / 1ps

// Channel   Direction  Handshake                 Beat
// request   in         i_in_valid / o_in_stall   i_in_beat  (kvt_pkg::t_in_beat)
// answer    out        o_out_valid / i_out_stall o_out_beat (kvt_pkg::t_out_beat)
//
// A request is registered on acceptance and executed when the answer register is free or
// being emptied; its answer is then registered and held until the answer side takes it.
// Each cell compares its key in parallel; the free slot is found by a token
// that ripples along the chain of cells.
// One request per cycle when the answer side does not stall; a stalled answer holds
// execution, then the input. Synchronous active-low reset empties the table at once.

module key_value_table_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  kvt_pkg::t_in_beat  i_in_beat,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output kvt_pkg::t_out_beat o_out_beat
);

    logic                         r_pend;
    kvt_pkg::t_in_beat            r_req;
    logic                         r_out_valid;
    kvt_pkg::t_out_beat           r_out;
    kvt_pkg::t_out_beat           n_out;
    logic                         exec;
    logic                         in_acc;
    logic                         any_hit;
    logic                         full;
    logic [kvt_pkg::VAL_W-1:0]    rd_or;
    logic [kvt_pkg::ENTRIES-1:0]  match_vec;
    logic [kvt_pkg::ENTRIES-1:0]  valid_vec;
    logic [kvt_pkg::ENTRIES:0]    claim;
    kvt_pkg::t_cell_cmd           cmd;
    kvt_pkg::t_cell_stat          stat [kvt_pkg::ENTRIES];

    // Execute when the answer register is free or being emptied.
    assign exec       = r_pend && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_pend && !exec;
    assign in_acc     = i_in_valid && !o_in_stall;

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out;

    // Broadcast command.
    always_comb begin
        cmd.exec    = exec;
        cmd.opcode  = r_req.opcode;
        cmd.any_hit = any_hit;
        cmd.key     = r_req.key;
        cmd.value   = r_req.value;
    end

    // Row of cells with the free-slot token chain.
    assign claim[0] = 1'b1;
    for (genvar g = 0; g < kvt_pkg::ENTRIES; g++) begin : g_cell
        kvt_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_cmd      (cmd),
            .i_claim_in (claim[g]),
            .o_stat     (stat[g])
        );
        assign claim[g+1]   = stat[g].claim_out;
        assign match_vec[g] = stat[g].match;
        assign valid_vec[g] = stat[g].valid;
    end

    assign any_hit = |match_vec;
    assign full    = claim[kvt_pkg::ENTRIES];

    // At most one cell matches, so the masked values combine by OR.
    always_comb begin
        rd_or = '0;
        for (int i = 0; i < kvt_pkg::ENTRIES; i++) begin
            rd_or = rd_or | stat[i].rd_value;
        end
    end

    // Answer for the request under execution.
    always_comb begin
        n_out.status     = kvt_pkg::ST_OK;
        n_out.read_value = '0;
        case (r_req.opcode)
            kvt_pkg::OP_CLEAR: n_out.status = kvt_pkg::ST_OK;
            kvt_pkg::OP_INSERT: begin
                if (any_hit) begin
                    n_out.status = kvt_pkg::ST_EXISTS;
                end else if (full) begin
                    n_out.status = kvt_pkg::ST_FULL;
                end
            end
            kvt_pkg::OP_ERASE: begin
                if (!any_hit) n_out.status = kvt_pkg::ST_ABSENT;
            end
            kvt_pkg::OP_READ: begin
                if (!any_hit) begin
                    n_out.status = kvt_pkg::ST_ABSENT;
                end else begin
                    n_out.read_value = rd_or;
                end
            end
            default: n_out.status = kvt_pkg::ST_OK;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_pend <= 1'b1;
            end else if (exec) begin
                r_pend <= 1'b0;
            end
            if (exec) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_req <= i_in_beat;
        end
        if (exec) begin
            r_out <= n_out;
        end
    end

`ifndef ASSERT_OFF
    // Keys are unique, so no two cells may match.
    a_unique_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(match_vec))
        else $error("more than one cell matches the key");

    // A clear empties every cell.
    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        exec && (r_req.opcode == kvt_pkg::OP_CLEAR) |=> (valid_vec == '0))
        else $error("cells still valid after clear");

    // A successful insert fills exactly one more cell.
    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        exec && (r_req.opcode == kvt_pkg::OP_INSERT) && !any_hit && !full |=>
        ($countones(valid_vec) == $countones($past(valid_vec)) + 1))
        else $error("insert did not fill one cell");

    // Every execution leaves an answer waiting.
    a_exec_answers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        exec |=> r_out_valid)
        else $error("executed request left no answer");
`endif

endmodule

@@ src/kvt_cell.sv @@
`timescale 1ns / 1ps

module kvt_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  kvt_pkg::t_cell_cmd i_cmd,
    input  logic               i_claim_in,
    output kvt_pkg::t_cell_stat o_stat
);

    logic                      r_valid;
    logic                      n_valid;
    logic [kvt_pkg::KEY_W-1:0] r_key;
    logic [kvt_pkg::VAL_W-1:0] r_value;
    logic                      match;
    logic                      take;
    logic                      write_en;

    // Compare the stored key against the request key.
    assign match = r_valid && (r_key == i_cmd.key);

    // The free-slot token stops at the first empty cell of the chain.
    assign take = i_claim_in && !r_valid;

    assign write_en = i_cmd.exec && (i_cmd.opcode == kvt_pkg::OP_INSERT) &&
                      !i_cmd.any_hit && take;

    // Report to the top level and pass the token on.
    always_comb begin
        o_stat.match     = match;
        o_stat.valid     = r_valid;
        o_stat.claim_out = i_claim_in && r_valid;
        o_stat.rd_value  = match ? r_value : '0;
    end

    // Next state of the valid bit.
    always_comb begin
        n_valid = r_valid;
        if (i_cmd.exec) begin
            case (i_cmd.opcode)
                kvt_pkg::OP_CLEAR:  n_valid = 1'b0;
                kvt_pkg::OP_ERASE:  if (match) n_valid = 1'b0;
                kvt_pkg::OP_INSERT: if (write_en) n_valid = 1'b1;
                default:            n_valid = r_valid;
            endcase
        end
    end

    // Valid bit is control state and is reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Key and value are payload and carry no reset.
    always_ff @(posedge i_clk) begin
        if (write_en) begin
            r_key   <= i_cmd.key;
            r_value <= i_cmd.value;
        end
    end

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
    import kvt_pkg::*;

    localparam int CYCLE_LIMIT = 150000;
    localparam int HOLD_CYCLES = 400;
    localparam int RANDOM_PER_PHASE = 230;
    localparam int POOL_SIZE = 24;

    // How the two sides idle while a stretch of requests is offered.
    typedef enum int unsigned {
        PACE_RX_SLOW,
        PACE_TX_SLOW,
        PACE_STEADY
    } t_pace;

    // One planned request, with how it is to be offered.
    typedef struct {
        t_in_beat beat;
        t_pace    pace;
        bit       drain_first;
        bit       hold_rx;
    } t_planned_req;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    t_in_beat  in_beat = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_beat out_beat;

    t_planned_req request_plan[$];
    t_out_beat    answers_due[$];
    t_out_beat    due_answer;
    t_pace        fill_pace = PACE_RX_SLOW;
    logic [31:0]  key_pool [POOL_SIZE];

    // Shadow copy of the table contents.
    logic [KEY_W-1:0] cell_key [ENTRIES];
    logic [VAL_W-1:0] cell_value [ENTRIES];
    bit               cell_used [ENTRIES] = '{default: 1'b0};

    bit          req_taken = 1'b0;
    int unsigned rx_idle_pct = 0;
    int unsigned hold_reqs = 0;
    int unsigned hold_served = 0;
    int unsigned hold_left = 0;
    int unsigned cycles = 0;
    int unsigned mismatches = 0;

    key_value_table_top dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_beat   (in_beat),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_beat  (out_beat)
    );

    initial begin
        forever #4 clk = ~clk;
    end

    // Applies one request to the shadow table and returns the answer it must give.
    function automatic t_out_beat apply_request(t_in_beat req);
        t_out_beat ans;
        int        hit;
        int        slot;
        ans.status = ST_OK;
        ans.read_value = '0;
        hit = -1;
        slot = -1;
        if (req.opcode == OP_CLEAR) begin
            for (int i = 0; i < ENTRIES; i++) cell_used[i] = 1'b0;
        end else begin
            // Scanning downwards leaves the lowest matching and lowest free cell.
            for (int i = ENTRIES - 1; i >= 0; i--) begin
                if (cell_used[i] && cell_key[i] == req.key) hit = i;
                if (!cell_used[i]) slot = i;
            end
            case (req.opcode)
                OP_INSERT: begin
                    if (hit >= 0) begin
                        ans.status = ST_EXISTS;
                    end else if (slot < 0) begin
                        ans.status = ST_FULL;
                    end else begin
                        cell_key[slot] = req.key;
                        cell_value[slot] = req.value;
                        cell_used[slot] = 1'b1;
                    end
                end
                OP_ERASE: begin
                    if (hit < 0) ans.status = ST_ABSENT;
                    else cell_used[hit] = 1'b0;
                end
                default: begin
                    if (hit < 0) ans.status = ST_ABSENT;
                    else ans.read_value = cell_value[hit];
                end
            endcase
        end
        return ans;
    endfunction

    function automatic void plan_req(t_opcode op, logic [31:0] k, logic [31:0] v,
                                     bit drain = 1'b0, bit hold = 1'b0);
        t_planned_req item;
        item.beat.opcode = op;
        item.beat.key = k;
        item.beat.value = v;
        item.pace = fill_pace;
        item.drain_first = drain;
        item.hold_rx = hold;
        request_plan.push_back(item);
    endfunction

    function automatic int unsigned idle_pct(bit sender, t_pace pace);
        case (pace)
            PACE_RX_SLOW: return sender ? 9 : 50;
            PACE_TX_SLOW: return sender ? 50 : 9;
            default:      return 0;
        endcase
    endfunction

    // Keys mostly come from a small pool so that hits, duplicates and a full
    // table are common; the rest are fresh random patterns.
    function automatic logic [31:0] pick_key();
        if ($urandom_range(99) < 85) return key_pool[$urandom_range(POOL_SIZE - 1)];
        return $urandom;
    endfunction

    // Request driver: a beat is held until it is taken, then the next one follows.
    always @(negedge clk) begin
        if (rst_n && (!in_valid || req_taken)) begin
            if (request_plan.size() == 0) begin
                in_valid <= 1'b0;
            end else if (request_plan[0].drain_first && answers_due.size() != 0) begin
                in_valid <= 1'b0;
            end else if ($urandom_range(99) < idle_pct(1'b1, request_plan[0].pace)) begin
                in_valid <= 1'b0;
            end else begin
                in_beat <= request_plan[0].beat;
                in_valid <= 1'b1;
                rx_idle_pct <= idle_pct(1'b0, request_plan[0].pace);
                if (request_plan[0].hold_rx) hold_reqs <= hold_reqs + 1;
                void'(request_plan.pop_front());
            end
        end
    end

    // Answer receiver: random stalls, or a long hold-off when one is requested.
    always @(negedge clk) begin
        if (hold_reqs != hold_served) begin
            hold_served = hold_reqs;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(99) < rx_idle_pct);
        end
    end

    // Monitor: checks each answer beat against the oldest prediction, then
    // predicts for any request beat taken at this edge.
    always @(posedge clk) begin
        cycles = cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            req_taken = 1'b0;
            if (rst_n) begin
                if (out_valid && !out_stall) begin
                    if (answers_due.size() == 0) begin
                        $error("answer beat with no request outstanding: status %0d value %h",
                               out_beat.status, out_beat.read_value);
                        mismatches = mismatches + 1;
                    end else begin
                        due_answer = answers_due.pop_front();
                        if (out_beat.status !== due_answer.status) begin
                            $error("status: expected %0d, actual %0d",
                                   due_answer.status, out_beat.status);
                            mismatches = mismatches + 1;
                        end
                        if (out_beat.read_value !== due_answer.read_value) begin
                            $error("read_value: expected %h, actual %h",
                                   due_answer.read_value, out_beat.read_value);
                            mismatches = mismatches + 1;
                        end
                    end
                end
                if (in_valid && !in_stall) begin
                    req_taken = 1'b1;
                    answers_due.push_back(apply_request(in_beat));
                end
            end
        end
    end

    // Stimulus plan, reset and end of run.
    initial begin
        int unsigned r;
        t_opcode     op;
        for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = $urandom;
        key_pool[0] = 32'h8000_0000;
        key_pool[1] = 32'h7FFF_FFFF;
        key_pool[2] = 32'h0000_0000;
        key_pool[3] = 32'hFFFF_FFFF;

        // Directed part: empty-table cases, extreme keys and values, duplicates,
        // a full table, and a duplicate insert into a full table.
        fill_pace = PACE_RX_SLOW;
        plan_req(OP_CLEAR, 32'h0, 32'h0);
        plan_req(OP_READ, 32'h1234_5678, 32'hFFFF_FFFF);
        plan_req(OP_ERASE, 32'h8000_0000, 32'h0);
        plan_req(OP_INSERT, 32'h8000_0000, 32'h7FFF_FFFF);
        plan_req(OP_INSERT, 32'h7FFF_FFFF, 32'h8000_0000);
        plan_req(OP_INSERT, 32'h0000_0000, 32'h0000_0000);
        plan_req(OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        plan_req(OP_INSERT, 32'h7FFF_FFFF, 32'h1111_1111);
        plan_req(OP_READ, 32'h8000_0000, 32'h0);
        plan_req(OP_READ, 32'h7FFF_FFFF, 32'hAAAA_AAAA);
        plan_req(OP_ERASE, 32'h0000_0000, 32'h5555_5555);
        plan_req(OP_READ, 32'h0000_0000, 32'h0);
        for (int i = 0; i < ENTRIES - 3; i++) plan_req(OP_INSERT, 32'h100 + i, $urandom);
        plan_req(OP_INSERT, 32'h5555_5555, 32'h1);
        plan_req(OP_INSERT, 32'hFFFF_FFFF, 32'h2);
        plan_req(OP_READ, 32'hFFFF_FFFF, 32'h0);
        plan_req(OP_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

        // Random part in three phases of pacing.
        for (int phase = 0; phase < 3; phase++) begin
            fill_pace = t_pace'(phase);
            for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
                r = $urandom_range(99);
                if (r < 40) op = OP_INSERT;
                else if (r < 60) op = OP_ERASE;
                else if (r < 96) op = OP_READ;
                else op = OP_CLEAR;
                if (n == 0 && phase > 0) begin
                    plan_req(op, pick_key(), $urandom, 1'b1, 1'b0);
                end else if (n == 50 && fill_pace == PACE_STEADY) begin
                    plan_req(op, pick_key(), $urandom, 1'b0, 1'b1);
                end else if ($urandom_range(99) < 2) begin
                    // A burst of fresh inserts drives the table to full.
                    for (int b = 0; b < ENTRIES; b++) plan_req(OP_INSERT, $urandom, $urandom);
                end else begin
                    plan_req(op, pick_key(), $urandom);
                end
            end
        end

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (request_plan.size() != 0 || in_valid || answers_due.size() != 0)
            @(negedge clk);
        repeat (10) @(posedge clk);
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

@@ key_value_table_top.f @@
src/kvt_pkg.sv
src/kvt_cell.sv
src/key_value_table_top.sv
bench/testbench.sv
